FILE: sv/acp_pkg.sv
// ---------------------------------------------------------------------------
// acp_pkg
// Shared constants, types and keyword table of the AT command line parser.
// ---------------------------------------------------------------------------
package acp_pkg;

  // line store geometry
  localparam int LINE_DEPTH = 256;
  localparam int AW         = $clog2(LINE_DEPTH);
  localparam int NAME_LIMIT = 32;
  localparam int NW         = $clog2(NAME_LIMIT);

  // payload widths
  localparam int BW  = 8;
  localparam int SW  = 2;
  localparam int KW  = 2;
  localparam int CW  = 4;
  localparam int LW  = 8;

  // characters
  localparam logic [BW-1:0] CH_UA    = 8'h41;
  localparam logic [BW-1:0] CH_LA    = 8'h61;
  localparam logic [BW-1:0] CH_UT    = 8'h54;
  localparam logic [BW-1:0] CH_LT    = 8'h74;
  localparam logic [BW-1:0] CH_LZ    = 8'h7a;
  localparam logic [BW-1:0] CH_CR    = 8'h0d;
  localparam logic [BW-1:0] CH_BS    = 8'h08;
  localparam logic [BW-1:0] CH_PLUS  = 8'h2b;
  localparam logic [BW-1:0] CH_EQ    = 8'h3d;
  localparam logic [BW-1:0] CH_QMARK = 8'h3f;
  localparam logic [BW-1:0] CASE_OFS = 8'h20;

  // line status codes
  localparam logic [SW-1:0] ST_EMPTY    = 2'd0;
  localparam logic [SW-1:0] ST_FOUND    = 2'd1;
  localparam logic [SW-1:0] ST_UNKNOWN  = 2'd2;
  localparam logic [SW-1:0] ST_OVERFLOW = 2'd3;

  // command kinds
  localparam logic [KW-1:0] KIND_TEST  = 2'd0;
  localparam logic [KW-1:0] KIND_READ  = 2'd1;
  localparam logic [KW-1:0] KIND_WRITE = 2'd2;
  localparam logic [KW-1:0] KIND_EXEC  = 2'd3;

  // keyword table, text right-justified in each entry
  localparam int NUM_KEYS = 14;
  localparam int KEY_MAX  = 16;
  localparam logic [KEY_MAX*8-1:0] KEY_TEXT [NUM_KEYS] = '{
    "TIME", "LOCALIP", "SAVESETTINGS", "SERVERHOST", "SERVERPORT",
    "SERVERURI", "CHARGEPOINTID", "RECONNECT", "CHARGEPOINTSTATE",
    "LOCALLISTSHOW", "LOCALLISTADD", "LOCALLISTDELETE", "LOCALLISTCLEAR",
    "LOCALLISTSAVE"
  };
  localparam int KEY_LEN [NUM_KEYS] = '{4, 7, 12, 10, 10, 9, 13, 9, 16, 13, 12, 15, 14, 13};

  // write port of the line store
  typedef struct packed {
    logic          en;
    logic [AW-1:0] addr;
    logic [BW-1:0] data;
  } store_wr_t;

  // control of the keyword matcher
  typedef struct packed {
    logic clear;
    logic step;
  } match_ctl_t;

  // upper-case a..z only
  function automatic logic [BW-1:0] to_upper(input logic [BW-1:0] c);
    logic [BW-1:0] r;
    r = c;
    if (c >= CH_LA && c <= CH_LZ) begin
      r = c - CASE_OFS;
    end
    return r;
  endfunction

  // character i of keyword k, zero past its end
  function automatic logic [BW-1:0] key_char(input int k, input int i);
    logic [BW-1:0] r;
    r = '0;
    if (i < KEY_LEN[k]) begin
      r = KEY_TEXT[k][(KEY_LEN[k]-1-i)*8 +: 8];
    end
    return r;
  endfunction

endpackage

FILE: sv/acp_intf.sv
// ---------------------------------------------------------------------------
// acp_in_if / acp_out_if
// Valid/ready channels of the AT command line parser.
// ---------------------------------------------------------------------------
interface acp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface acp_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] line_status;
  logic [1:0] command_kind;
  logic [3:0] command_code;
  logic [7:0] arg_offset;
  logic [7:0] line_length;

  modport source (output valid, output line_status, output command_kind,
                  output command_code, output arg_offset, output line_length,
                  input ready);
  modport sink   (input valid, input line_status, input command_kind,
                  input command_code, input arg_offset, input line_length,
                  output ready);
endinterface

FILE: sv/acp_line_store.sv
// ---------------------------------------------------------------------------
// acp_line_store
// Single write, single read line memory with registered read data.
// ---------------------------------------------------------------------------
module acp_line_store import acp_pkg::*; (
  input  logic          clk_i,
  input  store_wr_t     wr_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [BW-1:0] rd_data_o
);

  logic [BW-1:0] mem_q [LINE_DEPTH];
  logic [BW-1:0] rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  // read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: sv/acp_key_match.sv
// ---------------------------------------------------------------------------
// acp_key_match
// Keyword matcher: one name character per step against all keywords.
// ---------------------------------------------------------------------------
module acp_key_match import acp_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  match_ctl_t    ctl_i,
  input  logic [NW-1:0] idx_i,
  input  logic [BW-1:0] ch_i,
  input  logic [NW-1:0] name_len_i,
  output logic [CW-1:0] code_o
);

  logic [NUM_KEYS-1:0] alive_q, alive_d;
  logic [BW-1:0]       up_ch;

  assign up_ch = to_upper(ch_i);

  // drop keywords that differ at this position
  always_comb begin
    alive_d = alive_q;
    if (ctl_i.clear) begin
      alive_d = '1;
    end else if (ctl_i.step) begin
      for (int k = 0; k < NUM_KEYS; k++) begin
        if (int'(idx_i) >= KEY_LEN[k] || up_ch != key_char(k, int'(idx_i))) begin
          alive_d[k] = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alive_q <= '1;
    end else begin
      alive_q <= alive_d;
    end
  end

  // lowest surviving keyword of matching length
  always_comb begin
    code_o = '0;
    for (int k = NUM_KEYS - 1; k >= 0; k--) begin
      if (alive_q[k] && KEY_LEN[k] == int'(name_len_i)) begin
        code_o = CW'(k + 1);
      end
    end
  end

endmodule

FILE: sv/at_command_line_parser.sv
// ---------------------------------------------------------------------------
// at_command_line_parser
// Frames AT command lines from received bytes and recognises the command.
// ---------------------------------------------------------------------------
// channel | dir | payload                                           | role
// rx_i    | in  | rx_byte                                           | received bytes
// res_o   | out | line_status command_kind command_code arg_offset  | one per line end
//         |     | line_length                                       | or overflow
//
// A byte is taken in idle; an overflowing byte also passes through emit. A
// carriage return on a non-empty line starts a delimiter pass over the
// stored bytes, then a keyword pass over the name (skipped if the line is
// already unknown), then emit; an empty line goes straight to emit. Reset
// sets the phase to waiting for A and the count to 0; the store is never
// read past the count, so it needs no clearing. A stalled result holds the
// block in its emit step until the output register frees.
// ---------------------------------------------------------------------------
module at_command_line_parser import acp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  acp_in_if.sink    rx_i,
  acp_out_if.source res_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_NAME = 4'b0100,
    S_EMIT = 4'b1000
  } state_e;

  typedef enum logic [2:0] {
    PH_WAIT_A = 3'b001,
    PH_WAIT_T = 3'b010,
    PH_LINE   = 3'b100
  } phase_e;

  typedef struct packed {
    logic [SW-1:0] status;
    logic [KW-1:0] kind;
    logic [CW-1:0] code;
    logic [LW-1:0] arg;
    logic [LW-1:0] len;
  } res_t;

  state_e        state_q, state_d;
  phase_e        phase_q, phase_d;
  logic [AW-1:0] count_q, count_d;
  res_t          pend_q, pend_d;
  res_t          res_q, res_d;
  logic          out_valid_q, out_valid_d;

  logic [AW-1:0] len_q, len_d;
  logic [AW-1:0] rd_idx_q, rd_idx_d;
  logic          rd_pend_q, rd_pend_d;
  logic [AW-1:0] rd_pos_q, rd_pos_d;
  logic          prev_eq_q, prev_eq_d;
  logic          plus_ok_q, plus_ok_d;
  logic          fnd_t_q, fnd_t_d, fnd_r_q, fnd_r_d, fnd_w_q, fnd_w_d;
  logic [AW-1:0] pos_t_q, pos_t_d, pos_r_q, pos_r_d, pos_w_q, pos_w_d;
  logic [KW-1:0] kind_q, kind_d;
  logic [AW-1:0] arg_q, arg_d;
  logic [NW-1:0] name_len_q, name_len_d;

  logic          rx_acc;
  logic [BW-1:0] c;
  logic [AW-1:0] rd_lim;
  logic          rd_issue;
  logic          pass_done;
  logic [BW-1:0] rd_data;
  store_wr_t     wr;
  match_ctl_t    mctl;
  logic [CW-1:0] code;

  logic [KW-1:0] sel_kind;
  logic [AW-1:0] sel_pos, sel_arg, sel_name;
  res_t          unknown_res;

  assign rx_acc   = rx_i.valid && rx_i.ready;
  assign c        = rx_i.rx_byte;
  assign rx_i.ready = (state_q == S_IDLE);

  // read sequencing shared by both passes
  assign rd_lim    = (state_q == S_SCAN) ? len_q : (AW'(name_len_q) + AW'(1));
  assign rd_issue  = (state_q == S_SCAN || state_q == S_NAME) && (rd_idx_q < rd_lim);
  assign pass_done = !rd_pend_q && (rd_idx_q == rd_lim);

  // pick the command type from the delimiter search
  always_comb begin
    if (fnd_t_q) begin
      sel_kind = KIND_TEST;
      sel_pos  = pos_t_q;
      sel_arg  = pos_t_q + AW'(2);
    end else if (fnd_r_q) begin
      sel_kind = KIND_READ;
      sel_pos  = pos_r_q;
      sel_arg  = pos_r_q + AW'(1);
    end else if (fnd_w_q) begin
      sel_kind = KIND_WRITE;
      sel_pos  = pos_w_q;
      sel_arg  = pos_w_q + AW'(1);
    end else begin
      sel_kind = KIND_EXEC;
      sel_pos  = len_q;
      sel_arg  = len_q;
    end
    sel_name = sel_pos - AW'(1);
  end

  assign unknown_res = '{status: ST_UNKNOWN, kind: '0, code: '0, arg: '0, len: LW'(len_q)};

  // sequencer
  always_comb begin
    state_d    = state_q;
    phase_d    = phase_q;
    count_d    = count_q;
    pend_d     = pend_q;
    len_d      = len_q;
    rd_idx_d   = rd_idx_q;
    rd_pend_d  = rd_issue;
    rd_pos_d   = rd_idx_q;
    prev_eq_d  = prev_eq_q;
    plus_ok_d  = plus_ok_q;
    fnd_t_d    = fnd_t_q;
    fnd_r_d    = fnd_r_q;
    fnd_w_d    = fnd_w_q;
    pos_t_d    = pos_t_q;
    pos_r_d    = pos_r_q;
    pos_w_d    = pos_w_q;
    kind_d     = kind_q;
    arg_d      = arg_q;
    name_len_d = name_len_q;
    wr         = '{en: 1'b0, addr: count_q, data: c};
    mctl       = '{clear: 1'b0, step: 1'b0};

    if (rd_issue) begin
      rd_idx_d = rd_idx_q + AW'(1);
    end

    unique case (state_q)
      S_IDLE: begin
        if (rx_acc) begin
          unique case (phase_q)
            PH_WAIT_T: begin
              phase_d = (c == CH_UT || c == CH_LT) ? PH_LINE : PH_WAIT_A;
            end
            PH_LINE: begin
              if (c == CH_CR) begin
                phase_d   = PH_WAIT_A;
                count_d   = '0;
                len_d     = count_q;
                rd_idx_d  = '0;
                prev_eq_d = 1'b0;
                plus_ok_d = 1'b0;
                fnd_t_d   = 1'b0;
                fnd_r_d   = 1'b0;
                fnd_w_d   = 1'b0;
                if (count_q == '0) begin
                  pend_d  = '{status: ST_EMPTY, kind: '0, code: '0, arg: '0, len: '0};
                  state_d = S_EMIT;
                end else begin
                  state_d = S_SCAN;
                end
              end else if (c == CH_BS) begin
                if (count_q != '0) begin
                  count_d = count_q - AW'(1);
                end else begin
                  phase_d = PH_WAIT_T;
                end
              end else if (count_q != AW'(LINE_DEPTH - 1)) begin
                wr.en   = 1'b1;
                count_d = count_q + AW'(1);
              end else begin
                pend_d  = '{status: ST_OVERFLOW, kind: '0, code: '0, arg: '0,
                            len: LW'(count_q)};
                count_d = '0;
                phase_d = PH_WAIT_A;
                state_d = S_EMIT;
              end
            end
            default: begin
              if (c == CH_UA || c == CH_LA) begin
                phase_d = PH_WAIT_T;
              end
            end
          endcase
        end
      end

      S_SCAN: begin
        // delimiter search, one stored byte per cycle
        if (rd_pend_q) begin
          if (rd_pos_q == '0) begin
            plus_ok_d = (rd_data == CH_PLUS);
          end
          if (!fnd_t_q && prev_eq_q && rd_data == CH_QMARK) begin
            fnd_t_d = 1'b1;
            pos_t_d = rd_pos_q - AW'(1);
          end
          if (!fnd_r_q && rd_data == CH_QMARK) begin
            fnd_r_d = 1'b1;
            pos_r_d = rd_pos_q;
          end
          if (!fnd_w_q && rd_data == CH_EQ) begin
            fnd_w_d = 1'b1;
            pos_w_d = rd_pos_q;
          end
          prev_eq_d = (rd_data == CH_EQ);
        end
        if (pass_done) begin
          kind_d     = sel_kind;
          arg_d      = sel_arg;
          name_len_d = NW'(sel_name);
          if (!plus_ok_q || int'(sel_name) >= NAME_LIMIT) begin
            pend_d  = unknown_res;
            state_d = S_EMIT;
          end else begin
            rd_idx_d   = AW'(1);
            mctl.clear = 1'b1;
            state_d    = S_NAME;
          end
        end
      end

      S_NAME: begin
        // keyword compare, one name byte per cycle
        mctl.step = rd_pend_q;
        if (pass_done) begin
          if (code == '0) begin
            pend_d = unknown_res;
          end else begin
            pend_d = '{status: ST_FOUND, kind: kind_q, code: code, arg: LW'(arg_q),
                       len: LW'(len_q)};
          end
          state_d = S_EMIT;
        end
      end

      S_EMIT: begin
        if (!out_valid_q || res_o.ready) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // output register
  always_comb begin
    res_d       = res_q;
    out_valid_d = out_valid_q && !res_o.ready;
    if (state_q == S_EMIT && (!out_valid_q || res_o.ready)) begin
      res_d       = pend_q;
      out_valid_d = 1'b1;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= PH_WAIT_A;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      rd_pend_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      rd_pend_q   <= rd_pend_d;
    end
  end

  // scan and payload registers
  always_ff @(posedge clk_i) begin
    pend_q     <= pend_d;
    res_q      <= res_d;
    len_q      <= len_d;
    rd_idx_q   <= rd_idx_d;
    rd_pos_q   <= rd_pos_d;
    prev_eq_q  <= prev_eq_d;
    plus_ok_q  <= plus_ok_d;
    fnd_t_q    <= fnd_t_d;
    fnd_r_q    <= fnd_r_d;
    fnd_w_q    <= fnd_w_d;
    pos_t_q    <= pos_t_d;
    pos_r_q    <= pos_r_d;
    pos_w_q    <= pos_w_d;
    kind_q     <= kind_d;
    arg_q      <= arg_d;
    name_len_q <= name_len_d;
  end

  acp_line_store u_store (
    .clk_i     (clk_i),
    .wr_i      (wr),
    .rd_en_i   (rd_issue),
    .rd_addr_i (rd_idx_q),
    .rd_data_o (rd_data)
  );

  acp_key_match u_match (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (mctl),
    .idx_i      (NW'(rd_pos_q - AW'(1))),
    .ch_i       (rd_data),
    .name_len_i (name_len_q),
    .code_o     (code)
  );

  // result channel
  assign res_o.valid        = out_valid_q;
  assign res_o.line_status  = res_q.status;
  assign res_o.command_kind = res_q.kind;
  assign res_o.command_code = res_q.code;
  assign res_o.arg_offset   = res_q.arg;
  assign res_o.line_length  = res_q.len;

endmodule

FILE: sv/acp_checker.sv
// ---------------------------------------------------------------------------
// acp_checker
// Port-level checks on the result channel of the AT command line parser.
// ---------------------------------------------------------------------------
module acp_checker import acp_pkg::*; (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          out_valid,
  input logic          out_ready,
  input logic [SW-1:0] status,
  input logic [KW-1:0] kind,
  input logic [CW-1:0] code,
  input logic [LW-1:0] arg,
  input logic [LW-1:0] len
);

  // stalled transaction holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(code)
      && $stable(len))
    else $error("result changed while stalled");

  // only a recognised command carries kind, code and offset
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && status != ST_FOUND |-> kind == '0 && code == '0 && arg == '0)
    else $error("non-command result carries command fields");

  // recognised command has a keyword and an offset inside the line
  a_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && status == ST_FOUND |->
      code != '0 && int'(code) <= NUM_KEYS && arg <= len && len != '0)
    else $error("bad recognised command");

  // empty line reports no length
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && status == ST_EMPTY |-> len == '0)
    else $error("empty line with length");

endmodule

bind at_command_line_parser acp_checker u_acp_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .out_valid (res_o.valid),
  .out_ready (res_o.ready),
  .status    (res_o.line_status),
  .kind      (res_o.command_kind),
  .code      (res_o.command_code),
  .arg       (res_o.arg_offset),
  .len       (res_o.line_length)
);
